### rtl/color_pair_find_or_insert_table_assert.svh
// Assertion macros for the color pair find-or-insert table.
// Included by the top level; no other dependencies.
`ifndef COLOR_PAIR_FIND_OR_INSERT_TABLE_ASSERT_SVH
`define COLOR_PAIR_FIND_OR_INSERT_TABLE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define CPFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define CPFT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CPFT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPFT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/cpft_pkg.sv
// Package for the color pair find-or-insert table: field widths,
// parameter defaults, status codes and the packed pair type. No dependencies.
`timescale 1ns / 1ps

package cpft_pkg;

	localparam int TABLE_DEPTH_DEF  = 512;
	localparam int BASIC_COLORS_DEF = 8;

	localparam int COLOR_W  = 8;
	localparam int ID_W     = 10;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

	// fg in the upper byte, bg in the lower byte
	typedef struct packed {
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
	} pair_t;

endpackage

### rtl/color_pair_find_or_insert_table.sv
// Color pair find-or-insert table: one request (fg, bg) gives one result (pair_id, status).
// Basic pairs (both colors below BASIC_COLORS) are decoded from the key; the decode is
// registered at accept, and the result then waits for a free output register. Other keys
// scan appended slots, one registered memory read per cycle. One request at a time.
// Reset (arst_n low) clears control and sets the count to the basic pair count; the
// memory is not cleared, as only written slots are ever read. Depends on cpft_pkg.
`timescale 1ns / 1ps
`include "color_pair_find_or_insert_table_assert.svh"

module color_pair_find_or_insert_table #(
	parameter int TABLE_DEPTH  = cpft_pkg::TABLE_DEPTH_DEF,
	parameter int BASIC_COLORS = cpft_pkg::BASIC_COLORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] fg_color, [15:8] bg_color
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] pair_id, [15:10] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int AW      = $clog2(TABLE_DEPTH);
	localparam int CW      = $clog2(TABLE_DEPTH + 1);
	localparam int BASIC_N = BASIC_COLORS * BASIC_COLORS;
	localparam int PRELOAD = (BASIC_N < TABLE_DEPTH) ? BASIC_N : TABLE_DEPTH;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                          state_q;
	cpft_pkg::pair_t               key_q;
	logic                          basic_hit_q;
	logic [cpft_pkg::ID_W-1:0]     basic_id_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 rd_slot_q;
	logic                          rd_vld_s1;
	logic [CW-1:0]                 rd_slot_s1;
	cpft_pkg::pair_t               rd_data_s1;
	cpft_pkg::pair_t               mem [TABLE_DEPTH];

	logic                          out_vld_q;
	logic [cpft_pkg::ID_W-1:0]     out_id_q;
	logic [cpft_pkg::STATUS_W-1:0] out_status_q;

	cpft_pkg::pair_t               in_key;
	logic [15:0]                   basic_idx;
	logic                          basic_hit;
	logic                          accept;
	logic                          out_free;
	logic                          hit;
	logic                          scan_done;
	logic                          finish;
	logic                          advance;
	logic                          rd_issue;
	logic                          insert;
	logic [CW-1:0]                 hit_id_full;
	logic [CW-1:0]                 new_id_full;
	logic [cpft_pkg::ID_W-1:0]     res_id;
	logic [cpft_pkg::STATUS_W-1:0] res_status;

	assign in_key.fg = s_tdata[7:0];
	assign in_key.bg = s_tdata[15:8];

	// basic pairs sit at slot fg * BASIC_COLORS + bg and are never overwritten
	assign basic_idx = 16'(in_key.fg) * 16'(BASIC_COLORS) + 16'(in_key.bg);
	assign basic_hit = (16'(in_key.fg) < 16'(BASIC_COLORS))
		&& (16'(in_key.bg) < 16'(BASIC_COLORS))
		&& (basic_idx < 16'(PRELOAD));

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_vld_q || m_tready;
	assign hit       = rd_vld_s1 && (rd_data_s1 == key_q);
	assign scan_done = !rd_vld_s1 && (rd_slot_q == count_q);
	assign finish    = (state_q == ST_SCAN) && out_free && (basic_hit_q || hit || scan_done);
	// hold the read pipeline while a hit waits for the output register
	assign advance   = (state_q == ST_SCAN) && !basic_hit_q && !hit && !scan_done;
	assign rd_issue  = advance && (rd_slot_q != count_q);
	assign insert    = finish && !basic_hit_q && !hit && (count_q < CW'(TABLE_DEPTH));

	assign hit_id_full = rd_slot_s1 + CW'(1);
	assign new_id_full = count_q + CW'(1);

	always_comb begin
		if (basic_hit_q) begin
			res_id     = basic_id_q;
			res_status = cpft_pkg::STATUS_FOUND;
		end else if (hit) begin
			res_id     = cpft_pkg::ID_W'(hit_id_full);
			res_status = cpft_pkg::STATUS_FOUND;
		end else if (count_q < CW'(TABLE_DEPTH)) begin
			res_id     = cpft_pkg::ID_W'(new_id_full);
			res_status = cpft_pkg::STATUS_INSERTED;
		end else begin
			res_id     = '0;
			res_status = cpft_pkg::STATUS_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= CW'(PRELOAD);
			rd_slot_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_SCAN;
						rd_slot_q <= CW'(PRELOAD);
						rd_vld_s1 <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (finish) begin
						state_q   <= ST_IDLE;
						rd_vld_s1 <= 1'b0;
					end else if (advance) begin
						rd_vld_s1 <= rd_issue;
						if (rd_issue) begin
							rd_slot_q <= rd_slot_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (insert) begin
				count_q <= new_id_full;
			end
			if (finish) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q       <= in_key;
			basic_hit_q <= basic_hit;
			basic_id_q  <= cpft_pkg::ID_W'(basic_idx + 16'd1);
		end
		if (rd_issue) begin
			rd_slot_s1 <= rd_slot_q;
		end
		if (finish) begin
			out_id_q     <= res_id;
			out_status_q <= res_status;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (insert) begin
			mem[count_q[AW-1:0]] <= key_q;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[rd_slot_q[AW-1:0]];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(16 - cpft_pkg::ID_W){1'b0}}, out_id_q};
	assign m_tuser  = out_status_q;

	`CPFT_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1,
		(count_q >= CW'(PRELOAD)) && (count_q <= CW'(TABLE_DEPTH)))
	`CPFT_ASSERT_NXT(a_insert_grows, clk, arst_n, insert, count_q == $past(count_q) + CW'(1))
	`CPFT_ASSERT_IMP(a_full_id_zero, clk, arst_n,
		out_vld_q && (out_status_q == cpft_pkg::STATUS_FULL), out_id_q == '0)
	`CPFT_ASSERT_IMP(a_read_in_range, clk, arst_n, rd_issue,
		(rd_slot_q >= CW'(PRELOAD)) && (rd_slot_q < count_q))

endmodule

### tb/color_pair_find_or_insert_table_test.sv
// Self-checking bench for color_pair_find_or_insert_table: directed and random color
// pair requests, each result checked against a bench-side copy of the pair table.
// Depends on cpft_pkg and the block's RTL.
`timescale 1ns / 1ps

module color_pair_find_or_insert_table_test;

	localparam int DEPTH          = cpft_pkg::TABLE_DEPTH_DEF;
	localparam int BASIC          = cpft_pkg::BASIC_COLORS_DEF;
	localparam int PHASE_ITEMS    = 384;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int DIRECTED_COUNT = 18;

	typedef struct packed {
		logic [cpft_pkg::ID_W-1:0]     pair_id;
		logic [cpft_pkg::STATUS_W-1:0] status;
	} pair_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // [7:0] fg_color, [15:8] bg_color
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // [9:0] pair_id, [15:10] zero
	logic [1:0]  m_tuser;         // [1:0] status

	// fg in the upper byte: extremes, both sides of the basic range, repeats
	cpft_pkg::pair_t directed_pairs[DIRECTED_COUNT] = '{
		16'h0000, 16'h0707, 16'h0007, 16'h0700, 16'h0305, 16'h0800,
		16'h0008, 16'h0800, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0708,
		16'h0807, 16'h8001, 16'h0180, 16'hFFFF, 16'hAA55, 16'h55AA
	};

	cpft_pkg::pair_t pending_pairs[$];
	cpft_pkg::pair_t issued_pairs[$];
	pair_result_t    predicted_pair_ids[$];
	cpft_pkg::pair_t known_pairs[DEPTH];
	int              known_count   = 0;
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	bit              hold_request  = 1'b0;
	bit              hold_done     = 1'b0;
	int              hold_left     = 0;
	bit              req_taken     = 1'b0;
	int              mismatches    = 0;
	int              quiet_cycles  = 0;

	color_pair_find_or_insert_table #(
		.TABLE_DEPTH (DEPTH),
		.BASIC_COLORS(BASIC)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Search in slot order, append on a miss, report full when no slot is left.
	function automatic pair_result_t find_or_insert(input cpft_pkg::pair_t key);
		pair_result_t res;
		int slot;
		res.pair_id = '0;
		res.status  = cpft_pkg::STATUS_FULL;
		for (slot = 0; slot < known_count; slot++) begin
			if (known_pairs[slot] == key) begin
				res.pair_id = cpft_pkg::ID_W'(slot + 1);
				res.status  = cpft_pkg::STATUS_FOUND;
				return res;
			end
		end
		if (known_count < DEPTH) begin
			known_pairs[known_count] = key;
			known_count++;
			res.pair_id = cpft_pkg::ID_W'(known_count);
			res.status  = cpft_pkg::STATUS_INSERTED;
		end
		return res;
	endfunction

	function automatic void note_mismatch(input string what, input pair_result_t want);
		if (mismatches < 10) begin
			$display("%0t: %s: expected id %0d status %0d, got tdata %h tuser %0d", $realtime,
				what, want.pair_id, want.status, m_tdata, m_tuser);
		end
		mismatches++;
	endfunction

	// Mix fresh keys, basic pairs and repeats of keys already sent.
	task automatic queue_requests(input int count, input int fresh_pct);
		cpft_pkg::pair_t key;
		int roll;
		repeat (count) begin
			roll = $urandom_range(99, 0);
			if (roll < fresh_pct || issued_pairs.size() == 0) begin
				key.fg = 8'($urandom_range(255, 0));
				key.bg = 8'($urandom_range(255, 0));
				issued_pairs.push_back(key);
			end else if (roll < fresh_pct + 20) begin
				key.fg = 8'($urandom_range(BASIC - 1, 0));
				key.bg = 8'($urandom_range(BASIC - 1, 0));
			end else begin
				key = issued_pairs[$urandom_range(issued_pairs.size() - 1, 0)];
			end
			pending_pairs.push_back(key);
		end
	endtask

	task automatic wait_drained();
		while (pending_pairs.size() != 0 || s_tvalid || predicted_pair_ids.size() != 0)
			@(posedge clk);
	endtask

	// Request side: hold the offered transaction until taken, then offer the next one.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (pending_pairs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				s_tdata  <= {pending_pairs[0].bg, pending_pairs[0].fg};
				s_tvalid <= 1'b1;
				void'(pending_pairs.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result side: random backpressure, plus one long hold when requested.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_done) begin
			m_tready  <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_tready <= arst_n && ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// Check results first: a result accepted now always belongs to an earlier request.
	always @(posedge clk) begin
		cpft_pkg::pair_t key;
		pair_result_t want;
		req_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (predicted_pair_ids.size() == 0) begin
					want = '0;
					note_mismatch("unexpected result", want);
				end else begin
					want = predicted_pair_ids.pop_front();
					if (m_tdata[cpft_pkg::ID_W-1:0] !== want.pair_id
							|| m_tuser !== want.status
							|| m_tdata[15:cpft_pkg::ID_W] !== '0)
						note_mismatch("result mismatch", want);
				end
			end
			if (s_tvalid && s_tready) begin
				key.fg = s_tdata[7:0];
				key.bg = s_tdata[15:8];
				predicted_pair_ids.push_back(find_or_insert(key));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// basic pairs preloaded in slot order, saturating at the table depth
		for (int fg = 0; fg < BASIC; fg++) begin
			for (int bg = 0; bg < BASIC; bg++) begin
				if (known_count < DEPTH) begin
					known_pairs[known_count] = {8'(fg), 8'(bg)};
					known_count++;
				end
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 77;
		foreach (directed_pairs[i]) begin
			pending_pairs.push_back(directed_pairs[i]);
			if (directed_pairs[i].fg >= BASIC || directed_pairs[i].bg >= BASIC)
				issued_pairs.push_back(directed_pairs[i]);
		end
		queue_requests(PHASE_ITEMS, 60);
		wait_drained();

		send_idle_pct = 77;
		recv_idle_pct = 15;
		queue_requests(PHASE_ITEMS, 60);
		wait_drained();

		// no idling; the long result hold makes the block stall its input
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_requests(PHASE_ITEMS, 40);
		hold_request = 1'b1;
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && predicted_pair_ids.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### color_pair_find_or_insert_table.f
+incdir+rtl
rtl/cpft_pkg.sv
rtl/color_pair_find_or_insert_table.sv
tb/color_pair_find_or_insert_table_test.sv
